// ----- hdl/ses_pkg.sv -----
// ----------------------------------------------------------------------------
// ses_pkg: shared definitions for the spectral envelope smoother
// widths, filter constants, beat payloads and the cell control group
// ----------------------------------------------------------------------------
`default_nettype none

package ses_pkg;

    localparam int MAX_BINS = 1024;
    localparam int TAPS     = 20;
    localparam int LAG      = 10;

    localparam int IN_W     = 24;
    localparam int MAG_W    = 24;
    localparam int RAD_W    = 2 * MAG_W;
    localparam int COEF_W   = 16;
    localparam int ACC_W    = COEF_W + MAG_W;
    localparam int FRAC_W   = 16;
    localparam int FLUSH_W  = $clog2(LAG + 1);

    // unsigned q0.16 taps, window symmetric about tap 10 except for tap 0
    localparam logic [COEF_W-1:0] COEF [TAPS] = '{
        16'd1180, 16'd1593, 16'd2032, 16'd2477, 16'd2916,
        16'd3329, 16'd3696, 16'd4004, 16'd4234, 16'd4371,
        16'd4424, 16'd4371, 16'd4234, 16'd4004, 16'd3696,
        16'd3329, 16'd2916, 16'd2477, 16'd2032, 16'd1593
    };

    typedef struct packed {
        logic signed [IN_W-1:0] real_part;
        logic signed [IN_W-1:0] imag_part;
        logic                   last_bin;
    } bin_beat_t;

    typedef struct packed {
        logic [MAG_W-1:0] envelope;
        logic             last_of_frame;
    } env_beat_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } chain_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/ses_stream_if.sv -----
// ----------------------------------------------------------------------------
// ses_stream_if: valid/ready stream channel
// carries one payload beat per handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface ses_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/ses_isqrt.sv -----
// ----------------------------------------------------------------------------
// ses_isqrt: iterative integer square root
// restoring digit-by-digit root, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ses_isqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ses_pkg::RAD_W-1:0]   radicand,
    output logic                             done,
    output logic [ses_pkg::MAG_W-1:0]        root
);

    localparam int STEP_W = $clog2(ses_pkg::MAG_W);
    localparam int REM_W  = ses_pkg::MAG_W + 2;
    localparam int TRY_W  = REM_W + 2;

    logic [ses_pkg::RAD_W-1:0] rad_reg, rad_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [ses_pkg::MAG_W-1:0] root_reg, root_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      run_reg, run_next;
    logic                      done_reg, done_next;

    logic [TRY_W-1:0] rem_sh;
    logic [TRY_W-1:0] trial;

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_reg, rad_reg[ses_pkg::RAD_W-1 -: 2]};
    assign trial  = {{(TRY_W-ses_pkg::MAG_W-2){1'b0}}, root_reg, 2'b01};

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rad_next = {rad_reg[ses_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ses_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[ses_pkg::MAG_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ses_pkg::MAG_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ----- hdl/ses_cell.sv -----
// ----------------------------------------------------------------------------
// ses_cell: one tap of the smoothing filter
// holds one delay-line magnitude and adds its weighted value to a passing sum
// ----------------------------------------------------------------------------
`default_nettype none

module ses_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ses_pkg::chain_ctrl_t         ctrl,
    input  wire logic [ses_pkg::COEF_W-1:0]   coef,
    input  wire logic [ses_pkg::MAG_W-1:0]    data_in,
    output logic [ses_pkg::MAG_W-1:0]         data_out,
    input  wire logic [ses_pkg::ACC_W-1:0]    psum_in,
    input  wire logic                         valid_in,
    output logic [ses_pkg::ACC_W-1:0]         psum_out,
    output logic                              valid_out
);

    logic [ses_pkg::MAG_W-1:0] data_reg;
    logic [ses_pkg::ACC_W-1:0] psum_reg;
    logic                      valid_reg;
    logic [ses_pkg::ACC_W-1:0] prod;

    assign prod = coef * data_reg;

    // delay-line entry, zero after reset and after each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                data_reg <= '0;
            end
            else if (ctrl.shift)
            begin
                data_reg <= data_in;
            end
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            psum_reg <= psum_in + prod;
        end
    end

    assign data_out  = data_reg;
    assign psum_out  = psum_reg;
    assign valid_out = valid_reg;

endmodule

`default_nettype wire

// ----- hdl/spectral_envelope_smoother_top.sv -----
// ----------------------------------------------------------------------------
// spectral_envelope_smoother_top: smoothed magnitude spectrum
// each accepted bin passes the accept, square, start, square-root, shift, sum
// wave and emit steps in that order; the next bin is taken once the emit step
// (after a last bin, the flush) is done, so a bin is never taken while the one
// before is in work; the pace is set by the bit-serial square root and the sum
// wave through the 20-cell row; a last bin adds LAG (10) zero flush feeds
// reset: delay line, bin count and all handshake state clear asynchronously
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_envelope_smoother_top #(
    parameter int MAX_BINS = ses_pkg::MAX_BINS
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ses_stream_if.sink    spectrum,
    ses_stream_if.source  smoothed
);

    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int TAPS  = ses_pkg::TAPS;
    localparam int MAG_W = ses_pkg::MAG_W;
    localparam int ACC_W = ses_pkg::ACC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_START,
        S_ROOT,
        S_SHIFT,
        S_WAVE,
        S_EMIT
    } state_t;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                       state_reg, state_next;
    logic [MAG_W-1:0]             re_abs_reg, re_abs_next;
    logic [MAG_W-1:0]             im_abs_reg, im_abs_next;
    logic                         last_reg, last_next;
    logic [ses_pkg::RAD_W-1:0]    sq_re_reg, sq_re_next;
    logic [ses_pkg::RAD_W-1:0]    sq_im_reg, sq_im_next;
    logic [MAG_W-1:0]             mag_reg, mag_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [ses_pkg::FLUSH_W-1:0]  flush_cnt_reg, flush_cnt_next;
    logic                         launch_reg, launch_next;
    logic                         out_valid_reg, out_valid_next;
    ses_pkg::env_beat_t           out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]          re_raw, im_raw;
    logic [MAG_W-1:0]          re_abs, im_abs;
    logic [ses_pkg::RAD_W-1:0] sq_re, sq_im;
    logic [ses_pkg::RAD_W-1:0] radicand;
    logic                      root_start;
    logic                      root_done;
    logic [MAG_W-1:0]          root;

    ses_pkg::chain_ctrl_t      ctrl;
    logic [MAG_W-1:0]          shift_in;
    logic [MAG_W-1:0]          cell_data [TAPS+1];
    logic [ACC_W-1:0]          cell_psum [TAPS+1];
    logic                      cell_valid [TAPS+1];
    logic                      chain_done;
    logic [ACC_W-1:0]          chain_sum;

    logic                      emit_due;
    logic                      proceed;
    logic                      final_feed;
    logic                      in_accept;

    // magnitude of -2^23 is 2^23, which still fits an unsigned 24-bit word
    assign re_raw = spectrum.data.real_part;
    assign im_raw = spectrum.data.imag_part;
    assign re_abs = re_raw[MAG_W-1] ? (~re_raw + 1'b1) : re_raw;
    assign im_abs = im_raw[MAG_W-1] ? (~im_raw + 1'b1) : im_raw;

    // 24x24 squares, registered before the add
    assign sq_re = re_abs_reg * re_abs_reg;
    assign sq_im = im_abs_reg * im_abs_reg;

    // sum of squares is at most 2^47, no carry out of 48 bits
    assign radicand   = sq_re_reg + sq_im_reg;
    assign root_start = (state_reg == S_START);

    ses_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    // ------------------------------------------------------------------
    // filter row: magnitudes shift one cell per feed, then a partial sum
    // walks the row one cell per cycle while the entries hold still
    // ------------------------------------------------------------------
    // the bin's own magnitude goes in first, flush feeds push zeros
    assign shift_in      = (flush_cnt_reg == '0) ? mag_reg : '0;
    assign cell_data[0]  = shift_in;
    assign cell_psum[0]  = '0;
    assign cell_valid[0] = launch_reg;

    for (genvar i = 0; i < TAPS; i++)
    begin : g_cell
        ses_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .coef      (ses_pkg::COEF[i]),
            .data_in   (cell_data[i]),
            .data_out  (cell_data[i+1]),
            .psum_in   (cell_psum[i]),
            .valid_in  (cell_valid[i]),
            .psum_out  (cell_psum[i+1]),
            .valid_out (cell_valid[i+1])
        );
    end

    assign chain_done = cell_valid[TAPS];
    assign chain_sum  = cell_psum[TAPS];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign in_accept  = spectrum.valid && spectrum.ready;
    // no result until LAG filter inputs of this frame have gone by
    assign emit_due   = (count_reg >= CNT_W'(ses_pkg::LAG));
    // an emit waits only for a free output register
    assign proceed    = !emit_due || !out_valid_reg || smoothed.ready;
    assign final_feed = last_reg && (flush_cnt_reg == ses_pkg::FLUSH_W'(ses_pkg::LAG));

    always_comb
    begin
        state_next     = state_reg;
        re_abs_next    = re_abs_reg;
        im_abs_next    = im_abs_reg;
        last_next      = last_reg;
        sq_re_next     = sq_re_reg;
        sq_im_next     = sq_im_reg;
        mag_next       = mag_reg;
        count_next     = count_reg;
        flush_cnt_next = flush_cnt_reg;
        launch_next    = 1'b0;
        out_valid_next = out_valid_reg && !smoothed.ready;
        out_data_next  = out_data_reg;
        ctrl.shift     = 1'b0;
        ctrl.clear     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    re_abs_next = re_abs;
                    im_abs_next = im_abs;
                    last_next   = spectrum.data.last_bin;
                    state_next  = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                sq_re_next = sq_re;
                sq_im_next = sq_im;
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    mag_next   = root;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                ctrl.shift  = 1'b1;
                launch_next = 1'b1;
                state_next  = S_WAVE;
            end
            S_WAVE:
            begin
                if (chain_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (proceed)
                begin
                    if (emit_due)
                    begin
                        out_valid_next              = 1'b1;
                        out_data_next.envelope      =
                            chain_sum[ses_pkg::FRAC_W +: MAG_W];
                        out_data_next.last_of_frame = final_feed;
                    end
                    // count saturates, emission is unaffected once past LAG
                    if (count_reg != CNT_W'(MAX_BINS))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (final_feed)
                    begin
                        // end of frame: empty the row and restart the count
                        ctrl.clear     = 1'b1;
                        count_next     = '0;
                        flush_cnt_next = '0;
                        state_next     = S_IDLE;
                    end
                    else if (last_reg)
                    begin
                        flush_cnt_next = flush_cnt_reg + 1'b1;
                        state_next     = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            flush_cnt_reg <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            flush_cnt_reg <= flush_cnt_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        re_abs_reg   <= re_abs_next;
        im_abs_reg   <= im_abs_next;
        last_reg     <= last_next;
        sq_re_reg    <= sq_re_next;
        sq_im_reg    <= sq_im_next;
        mag_reg      <= mag_next;
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign spectrum.ready = (state_reg == S_IDLE);
    assign smoothed.valid = out_valid_reg;
    assign smoothed.data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // the sum wave only finishes while the sequencer waits for it
    a_wave_in_wave: assert property (@(posedge clk) disable iff (!rst_n)
        chain_done |-> (state_reg == S_WAVE))
        else $error("sum wave finished outside the wave step");

    // the square root only reports back while the sequencer waits for it
    a_root_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> (state_reg == S_ROOT))
        else $error("square root finished outside the root step");

    // a new bin is never taken in the middle of a flush
    a_no_accept_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        spectrum.ready |-> (flush_cnt_reg == '0))
        else $error("input ready during a flush");

    // a fresh result beat only comes from the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit step");
`endif

endmodule

`default_nettype wire
